FILE: rtl/core/dmc_pkg.sv
`timescale 1ns / 1ps

package dmc_pkg;

    // Field widths of the request and response payloads.
    parameter int ADDR_W = 12;
    parameter int DATA_W = 8;
    parameter int CNT_W  = 16;
    parameter int TIME_W = 20;

    // Request kinds.
    parameter logic REQ_LOAD = 1'b0;
    parameter logic REQ_READ = 1'b1;

    // Counter limits and the time charged for one miss.
    parameter logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;
    parameter logic [TIME_W-1:0] TIME_MAX  = 20'hFFFFF;
    parameter logic [TIME_W-1:0] MISS_TIME = 20'd20;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] ram_byte;
    } dmc_req_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_byte;
        logic [CNT_W-1:0]  misses_so_far;
        logic [TIME_W-1:0] time_so_far;
        logic [CNT_W-1:0]  reads_so_far;
    } dmc_rsp_t;

endpackage

FILE: rtl/core/dmc_req_if.sv
`timescale 1ns / 1ps

// Request channel: one load or read per handshake.
interface dmc_req_if;
    logic              valid;
    logic              ready;
    dmc_pkg::dmc_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/dmc_rsp_if.sv
`timescale 1ns / 1ps

// Response channel: one result per read request.
interface dmc_rsp_if;
    logic              valid;
    logic              ready;
    dmc_pkg::dmc_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/dmc_ram.sv
`timescale 1ns / 1ps

// Single-port synchronous RAM with a registered read.
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/core/direct_mapped_cache_read.sv
`timescale 1ns / 1ps

// Read-only direct-mapped cache in front of a byte-wide backing RAM. A load
// request writes one RAM byte and returns nothing; a read request returns the
// byte together with the hit flag and the saturating miss, time and read
// counters. The block handles one request at a time and accepts a new one
// only while it is idle; a finished response waits in an output register, so
// the next request can start before it is taken. A read miss fills the line
// one byte per cycle through the single port of the backing RAM. The address
// is split into tag, line and word by constant reciprocal multiplications
// in states S_DIV1 to S_DIV3. Each cached byte is stored with its line's tag
// in one RAM, so one read gives both; per-line valid bits are flip-flops that
// reset clears, so no clearing pass is needed after reset.
module direct_mapped_cache_read #(
    parameter int LINES      = 8,
    parameter int LINE_BYTES = 16,
    parameter int RAM_BYTES  = 4096
) (
    input  logic clk,
    input  logic rst_n,
    dmc_req_if.sink   req,
    dmc_rsp_if.source rsp
);

    localparam int ADDR_W   = dmc_pkg::ADDR_W;
    localparam int DATA_W   = dmc_pkg::DATA_W;
    localparam int ADDR_MAX = (1 << ADDR_W) - 1;

    // Field widths that follow from the geometry.
    localparam int WORD_W = $clog2(LINE_BYTES);
    localparam int LINE_W = $clog2(LINES);
    localparam int BLK_W  = $clog2(ADDR_MAX / LINE_BYTES + 1);
    localparam int TAG_Q  = ADDR_MAX / (LINE_BYTES * LINES);
    localparam int TAG_W  = (TAG_Q < 1) ? 1 : $clog2(TAG_Q + 1);
    localparam int CIDX_W = $clog2(LINES * LINE_BYTES);
    localparam int RAM_W  = $clog2(RAM_BYTES);
    localparam int CW_W   = TAG_W + DATA_W;

    // Reciprocals for exact division of narrow values by constants.
    localparam int PROD_W = 2 * ADDR_W + 1;
    localparam int LB_S   = ADDR_W + WORD_W;
    localparam int LB_M   = ((1 << LB_S) + LINE_BYTES - 1) / LINE_BYTES;
    localparam int LN_S   = BLK_W + LINE_W;
    localparam int LN_M   = ((1 << LN_S) + LINES - 1) / LINES;
    localparam int RM_S   = ADDR_W + RAM_W;
    localparam int RM_M   = ((1 << RM_S) + RAM_BYTES - 1) / RAM_BYTES;

    localparam bit RAM_WRAP = (RAM_BYTES < (1 << ADDR_W));
    localparam logic [ADDR_W-1:0] RAM_A    = ADDR_W'(RAM_WRAP ? RAM_BYTES : 0);
    localparam logic [RAM_W-1:0]  RAM_LAST = RAM_W'(RAM_BYTES - 1);
    localparam logic [RAM_W:0]    RAM_SPAN = (RAM_W + 1)'(RAM_BYTES);
    localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(LINE_BYTES - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DIV1 = 8'b0000_0010,
        S_DIV2 = 8'b0000_0100,
        S_DIV3 = 8'b0000_1000,
        S_TAG  = 8'b0001_0000,
        S_CHK  = 8'b0010_0000,
        S_FILL = 8'b0100_0000,
        S_RESP = 8'b1000_0000
    } state_t;

    // Control state.
    state_t                     state_reg, state_next;
    logic [LINES-1:0]           valid_reg, valid_next;
    logic [WORD_W-1:0]          fcnt_reg, fcnt_next;
    logic [dmc_pkg::CNT_W-1:0]  miss_reg, miss_next;
    logic [dmc_pkg::TIME_W-1:0] time_reg, time_next;
    logic [dmc_pkg::CNT_W-1:0]  reads_reg, reads_next;
    logic                       out_valid_reg, out_valid_next;

    // Request payload and decoded fields.
    logic                 rtype_reg, rtype_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [DATA_W-1:0]    wbyte_reg, wbyte_next;
    logic [BLK_W-1:0]     blk_reg, blk_next;
    logic [ADDR_W-1:0]    rq_reg, rq_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [RAM_W-1:0]     ram_idx_reg, ram_idx_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic [RAM_W-1:0]     fptr_reg, fptr_next;
    logic [CIDX_W-1:0]    lbase_reg, lbase_next;
    logic                 hit_reg, hit_next;
    logic [DATA_W-1:0]    rbyte_reg, rbyte_next;
    dmc_pkg::dmc_rsp_t    out_data_reg, out_data_next;

    // Memory ports.
    logic                 ram_we;
    logic [RAM_W-1:0]     ram_addr;
    logic [DATA_W-1:0]    ram_rdata;
    logic                 cache_we;
    logic [CIDX_W-1:0]    cache_addr;
    logic [CW_W-1:0]      cache_wdata;
    logic [CW_W-1:0]      cache_rdata;
    logic [TAG_W-1:0]     cache_tag;
    logic [DATA_W-1:0]    cache_byte;

    // Datapath helpers.
    logic [PROD_W-1:0]    blk_prod;
    logic [PROD_W-1:0]    rq_prod;
    logic [PROD_W-1:0]    ln_prod;
    logic [RAM_W:0]       base_sum;
    logic [RAM_W-1:0]     fptr_inc;
    logic                 hit_now;
    logic                 slot_free;

    dmc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_BYTES)
    ) u_backing_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wbyte_reg),
        .rdata (ram_rdata)
    );

    dmc_ram #(
        .WIDTH (CW_W),
        .DEPTH (LINES * LINE_BYTES)
    ) u_line_ram (
        .clk   (clk),
        .we    (cache_we),
        .addr  (cache_addr),
        .wdata (cache_wdata),
        .rdata (cache_rdata)
    );

    assign cache_tag  = cache_rdata[CW_W-1:DATA_W];
    assign cache_byte = cache_rdata[DATA_W-1:0];

    // Quotients by reciprocal multiplication.
    assign blk_prod = PROD_W'(addr_reg) * PROD_W'(LB_M);
    assign rq_prod  = PROD_W'(addr_reg) * PROD_W'(RM_M);
    assign ln_prod  = PROD_W'(blk_reg) * PROD_W'(LN_M);

    // First RAM address of the block, wrapped into the RAM.
    assign base_sum = {1'b0, ram_idx_reg}
                    + ((ram_idx_reg < RAM_W'(word_reg)) ? RAM_SPAN : '0)
                    - (RAM_W + 1)'(word_reg);

    assign fptr_inc  = (fptr_reg == RAM_LAST) ? '0 : fptr_reg + 1'b1;
    assign hit_now   = valid_reg[line_reg] && (cache_tag == tag_reg);
    assign slot_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // Sequencer: decode, tag check, line fill and response.
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        fcnt_next      = fcnt_reg;
        miss_next      = miss_reg;
        time_next      = time_reg;
        reads_next     = reads_reg;
        out_valid_next = out_valid_reg;
        rtype_next     = rtype_reg;
        addr_next      = addr_reg;
        wbyte_next     = wbyte_reg;
        blk_next       = blk_reg;
        rq_next        = rq_reg;
        word_next      = word_reg;
        tag_next       = tag_reg;
        ram_idx_next   = ram_idx_reg;
        line_next      = line_reg;
        fptr_next      = fptr_reg;
        lbase_next     = lbase_reg;
        hit_next       = hit_reg;
        rbyte_next     = rbyte_reg;
        out_data_next  = out_data_reg;

        ram_we      = 1'b0;
        ram_addr    = fptr_reg;
        cache_we    = 1'b0;
        cache_addr  = lbase_reg + CIDX_W'(fcnt_reg);
        cache_wdata = {tag_reg, ram_rdata};

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rtype_next = req.data.req_type;
                    addr_next  = req.data.address;
                    wbyte_next = req.data.ram_byte;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                blk_next   = BLK_W'(blk_prod >> LB_S);
                rq_next    = ADDR_W'(rq_prod >> RM_S);
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                word_next = WORD_W'(addr_reg
                          - ADDR_W'(ADDR_W'(blk_reg) * ADDR_W'(LINE_BYTES)));
                tag_next  = TAG_W'(ln_prod >> LN_S);
                if (RAM_WRAP)
                begin
                    ram_idx_next = RAM_W'(addr_reg - ADDR_W'(rq_reg * RAM_A));
                end
                else
                begin
                    ram_idx_next = RAM_W'(addr_reg);
                end
                state_next = S_DIV3;
            end
            S_DIV3:
            begin
                if (rtype_reg == dmc_pkg::REQ_LOAD)
                begin
                    ram_we     = 1'b1;
                    ram_addr   = ram_idx_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    line_next = LINE_W'(blk_reg
                              - BLK_W'(BLK_W'(tag_reg) * BLK_W'(LINES)));
                    fptr_next = RAM_W'(base_sum);
                    if (reads_reg < dmc_pkg::CNT_MAX)
                    begin
                        reads_next = reads_reg + 1'b1;
                    end
                    state_next = S_TAG;
                end
            end
            S_TAG:
            begin
                lbase_next = CIDX_W'(line_reg) * CIDX_W'(LINE_BYTES);
                cache_addr = CIDX_W'(line_reg) * CIDX_W'(LINE_BYTES)
                           + CIDX_W'(word_reg);
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (hit_now)
                begin
                    hit_next   = 1'b1;
                    rbyte_next = cache_byte;
                    state_next = S_RESP;
                end
                else
                begin
                    // Miss: charge it and issue the first RAM read of the fill.
                    hit_next = 1'b0;
                    if (miss_reg < dmc_pkg::CNT_MAX)
                    begin
                        miss_next = miss_reg + 1'b1;
                    end
                    if (time_reg > dmc_pkg::TIME_MAX - dmc_pkg::MISS_TIME)
                    begin
                        time_next = dmc_pkg::TIME_MAX;
                    end
                    else
                    begin
                        time_next = time_reg + dmc_pkg::MISS_TIME;
                    end
                    fptr_next  = fptr_inc;
                    fcnt_next  = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                // Each byte read last cycle goes into the line with the new tag.
                cache_we = 1'b1;
                if (fcnt_reg == word_reg)
                begin
                    rbyte_next = ram_rdata;
                end
                if (fcnt_reg == WORD_LAST)
                begin
                    valid_next[line_reg] = 1'b1;
                    state_next           = S_RESP;
                end
                else
                begin
                    fptr_next = fptr_inc;
                    fcnt_next = fcnt_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.hit           = hit_reg;
                    out_data_next.read_byte     = rbyte_reg;
                    out_data_next.misses_so_far = miss_reg;
                    out_data_next.time_so_far   = time_reg;
                    out_data_next.reads_so_far  = reads_reg;
                    state_next                  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            fcnt_reg      <= '0;
            miss_reg      <= '0;
            time_reg      <= '0;
            reads_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            fcnt_reg      <= fcnt_next;
            miss_reg      <= miss_next;
            time_reg      <= time_next;
            reads_reg     <= reads_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rtype_reg    <= rtype_next;
        addr_reg     <= addr_next;
        wbyte_reg    <= wbyte_next;
        blk_reg      <= blk_next;
        rq_reg       <= rq_next;
        word_reg     <= word_next;
        tag_reg      <= tag_next;
        ram_idx_reg  <= ram_idx_next;
        line_reg     <= line_next;
        fptr_reg     <= fptr_next;
        lbase_reg    <= lbase_next;
        hit_reg      <= hit_next;
        rbyte_reg    <= rbyte_next;
        out_data_reg <= out_data_next;
    end

    // The line RAM is written only during a fill.
    assert property (@(posedge clk) disable iff (!rst_n)
        cache_we |-> (state_reg == S_FILL))
        else $error("line RAM written outside a fill");

    // The miss count changes only on the tag check cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CHK) |=> $stable(miss_reg))
        else $error("miss count changed outside the tag check");

    // A completed fill leaves its line valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && fcnt_reg == WORD_LAST) |=> valid_reg[$past(line_reg)])
        else $error("filled line not marked valid");

    // Misses never outnumber reads in a response.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.misses_so_far <= out_data_reg.reads_so_far))
        else $error("miss count exceeds read count");

endmodule
